[hdl/integer_to_roman_text_top_macros.svh]
// ----------------------------------------------------------------------------
// Roman numeral text block - assertion macros
// Concurrent assertion wrappers clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_TEXT_TOP_MACROS_SVH
`define INTEGER_TO_ROMAN_TEXT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define I2R_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2r assertion failed");

// Next-cycle implication
`define I2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2r assertion failed");

`else

`define I2R_ASSERT_IMPL(label, ante, cons)
`define I2R_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/i2r_pkg.sv]
// ----------------------------------------------------------------------------
// Roman numeral text package
// Step tables, fixed words, limits and shared types.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int MAG_W     = 16;
    localparam int CHAR_W    = 7;
    localparam int NUM_STEPS = 13;
    localparam int IDX_W     = $clog2(NUM_STEPS);

    localparam logic [MAG_W-1:0] MAX_MAGNITUDE = 16'd3999;
    // Anything at or above this value is out of range
    localparam logic [MAG_W-1:0] LIMIT_OPERAND = MAX_MAGNITUDE + 16'd1;

    localparam int ZERO_LEN  = 5;
    localparam int MINUS_LEN = 6;
    localparam int CNT_W     = 3;

    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;

    typedef struct packed {
        logic              ge;
        logic [MAG_W-1:0]  diff;
    } t_cmp;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic              range_error;
    } t_char;

    function automatic logic [MAG_W-1:0] step_value(input logic [IDX_W-1:0] idx);
        logic [MAG_W-1:0] v;
        unique case (idx)
            4'd0:    v = 16'd1000;
            4'd1:    v = 16'd900;
            4'd2:    v = 16'd500;
            4'd3:    v = 16'd400;
            4'd4:    v = 16'd100;
            4'd5:    v = 16'd90;
            4'd6:    v = 16'd50;
            4'd7:    v = 16'd40;
            4'd8:    v = 16'd10;
            4'd9:    v = 16'd9;
            4'd10:   v = 16'd5;
            4'd11:   v = 16'd4;
            4'd12:   v = 16'd1;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] step_first(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            4'd0:                c = 7'(8'h4D); // M
            4'd1, 4'd3, 4'd4:    c = 7'(8'h43); // C
            4'd2:                c = 7'(8'h44); // D
            4'd5, 4'd7, 4'd8:    c = 7'(8'h58); // X
            4'd6:                c = 7'(8'h4C); // L
            4'd10:               c = 7'(8'h56); // V
            4'd9, 4'd11, 4'd12:  c = 7'(8'h49); // I
            default:             c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // CHAR_NONE when the step has a single letter
    function automatic logic [CHAR_W-1:0] step_second(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            4'd1:    c = 7'(8'h4D); // M
            4'd3:    c = 7'(8'h44); // D
            4'd5:    c = 7'(8'h43); // C
            4'd7:    c = 7'(8'h4C); // L
            4'd9:    c = 7'(8'h58); // X
            4'd11:   c = 7'(8'h56); // V
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] zero_char(input logic [CNT_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:       c = 7'(8'h6E); // n
            3'd1:       c = 7'(8'h75); // u
            3'd2, 3'd3: c = 7'(8'h6C); // l
            3'd4:       c = 7'(8'h61); // a
            default:    c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] minus_char(input logic [CNT_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:    c = 7'(8'h6D); // m
            3'd1:    c = 7'(8'h69); // i
            3'd2:    c = 7'(8'h6E); // n
            3'd3:    c = 7'(8'h75); // u
            3'd4:    c = 7'(8'h73); // s
            3'd5:    c = 7'(8'h20); // space
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

[hdl/i2r_if.sv]
// ----------------------------------------------------------------------------
// Roman numeral text channels
// Valid/ready interfaces for the value input and the character output.
// ----------------------------------------------------------------------------
interface i2r_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [i2r_pkg::MAG_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if;
    logic                       valid;
    logic                       ready;
    logic [i2r_pkg::CHAR_W-1:0] char_code;
    logic                       last_char;
    logic                       range_error;

    modport source (output valid, output char_code, output last_char,
                    output range_error, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input range_error, output ready);
endinterface

[hdl/i2r_cmp_sub.sv]
// ----------------------------------------------------------------------------
// Roman numeral text - shared compare/subtract unit
// One subtractor gives both magnitude >= operand and the remainder.
// ----------------------------------------------------------------------------
module i2r_cmp_sub (
    input  logic [i2r_pkg::MAG_W-1:0] i_mag,
    input  logic [i2r_pkg::MAG_W-1:0] i_operand,
    output i2r_pkg::t_cmp             o_res
);

    logic [i2r_pkg::MAG_W:0] w_diff;

    assign w_diff     = {1'b0, i_mag} - {1'b0, i_operand};
    assign o_res.ge   = ~w_diff[i2r_pkg::MAG_W];
    assign o_res.diff = w_diff[i2r_pkg::MAG_W-1:0];

endmodule

[hdl/i2r_seq.sv]
// ----------------------------------------------------------------------------
// Roman numeral text - sequencer
// Walks the step table with the shared unit and emits one character a beat.
// ----------------------------------------------------------------------------
module i2r_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2r_in_if.sink                i_in,
    output logic [i2r_pkg::MAG_W-1:0] o_mag,
    output logic [i2r_pkg::MAG_W-1:0] o_operand,
    input  i2r_pkg::t_cmp         i_cmp,
    output logic                  o_emit_valid,
    output i2r_pkg::t_char        o_emit,
    input  logic                  i_emit_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WORD,
        S_FIRST,
        S_SECOND
    } t_state;

    t_state                      r_state, n_state;
    logic [i2r_pkg::MAG_W-1:0]   r_mag,   n_mag;
    logic                        r_neg,   n_neg;
    logic                        r_zero,  n_zero;
    logic [i2r_pkg::IDX_W-1:0]   r_idx,   n_idx;
    logic [i2r_pkg::CNT_W-1:0]   r_cnt,   n_cnt;

    logic [i2r_pkg::MAG_W-1:0]   w_raw;
    logic [i2r_pkg::CHAR_W-1:0]  w_second;
    logic                        w_word_end;

    assign w_raw     = i_in.value;
    assign w_second  = i2r_pkg::step_second(r_idx);
    assign i_in.ready = (r_state == S_IDLE);
    assign o_mag     = r_mag;
    assign o_operand = (r_state == S_CHECK) ? i2r_pkg::LIMIT_OPERAND
                                            : i2r_pkg::step_value(r_idx);
    assign w_word_end = r_zero ? (r_cnt == i2r_pkg::CNT_W'(i2r_pkg::ZERO_LEN - 1))
                               : (r_cnt == i2r_pkg::CNT_W'(i2r_pkg::MINUS_LEN - 1));

    always_comb begin
        n_state      = r_state;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_zero       = r_zero;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        o_emit_valid = 1'b0;
        o_emit       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg   = w_raw[i2r_pkg::MAG_W-1];
                    n_mag   = w_raw[i2r_pkg::MAG_W-1] ? (~w_raw + 16'd1) : w_raw;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_cmp.ge) begin
                    o_emit_valid       = 1'b1;
                    o_emit.char_code   = i2r_pkg::CHAR_NONE;
                    o_emit.last_char   = 1'b1;
                    o_emit.range_error = 1'b1;
                    if (i_emit_ready) begin
                        n_state = S_IDLE;
                    end
                end else if (r_mag == '0) begin
                    n_zero  = 1'b1;
                    n_cnt   = '0;
                    n_state = S_WORD;
                end else if (r_neg) begin
                    n_zero  = 1'b0;
                    n_cnt   = '0;
                    n_state = S_WORD;
                end else begin
                    n_idx   = '0;
                    n_state = S_FIRST;
                end
            end
            S_WORD: begin
                o_emit_valid     = 1'b1;
                o_emit.char_code = r_zero ? i2r_pkg::zero_char(r_cnt)
                                          : i2r_pkg::minus_char(r_cnt);
                o_emit.last_char = r_zero && w_word_end;
                if (i_emit_ready) begin
                    if (w_word_end) begin
                        n_idx   = '0;
                        n_state = r_zero ? S_IDLE : S_FIRST;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_FIRST: begin
                if (!i_cmp.ge) begin
                    // step value too large: move to the next smaller one
                    n_idx = r_idx + 4'd1;
                end else begin
                    o_emit_valid     = 1'b1;
                    o_emit.char_code = i2r_pkg::step_first(r_idx);
                    o_emit.last_char = (w_second == i2r_pkg::CHAR_NONE) &&
                                       (i_cmp.diff == '0);
                    if (i_emit_ready) begin
                        if (w_second != i2r_pkg::CHAR_NONE) begin
                            n_state = S_SECOND;
                        end else begin
                            n_mag = i_cmp.diff;
                            if (i_cmp.diff == '0) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_SECOND: begin
                o_emit_valid     = 1'b1;
                o_emit.char_code = w_second;
                o_emit.last_char = (i_cmp.diff == '0);
                if (i_emit_ready) begin
                    n_mag   = i_cmp.diff;
                    n_state = (i_cmp.diff == '0) ? S_IDLE : S_FIRST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
            r_zero  <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_zero  <= n_zero;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
        r_mag <= n_mag;
    end

endmodule

[hdl/i2r_out_reg.sv]
// ----------------------------------------------------------------------------
// Roman numeral text - output register
// One-entry register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module i2r_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_emit_valid,
    input  i2r_pkg::t_char i_emit,
    output logic           o_emit_ready,
    i2r_out_if.source      o_out
);

    logic           r_valid;
    i2r_pkg::t_char r_char;

    // take a new beat when empty or when the held one leaves this cycle
    assign o_emit_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_emit_ready) begin
            r_valid <= i_emit_valid;
        end
        if (o_emit_ready && i_emit_valid) begin
            r_char <= i_emit;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.char_code   = r_char.char_code;
    assign o_out.last_char   = r_char.last_char;
    assign o_out.range_error = r_char.range_error;

endmodule

[hdl/integer_to_roman_text_top.sv]
// An accepted value goes through S_CHECK, S_FIRST (S_WORD for zero or minus)
// and the output register to o_out; a range error goes from S_CHECK to the
// output register. Each skipped step of the 13-entry table (at most 12) adds
// a compare in S_FIRST, one compare/subtract per cycle while output is not
// stalled. At most 21 characters per value; no new value is taken mid-text.
// Reset: synchronous, active low; clears sequencer state and output valid.
// ----------------------------------------------------------------------------
// Roman numeral text - top level
// Renders a signed 16-bit value as Roman numeral ASCII text, one beat each.
// ----------------------------------------------------------------------------
`include "integer_to_roman_text_top_macros.svh"

module integer_to_roman_text_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2r_in_if.sink    i_in,
    i2r_out_if.source o_out
);

    logic [i2r_pkg::MAG_W-1:0] w_mag;
    logic [i2r_pkg::MAG_W-1:0] w_operand;
    i2r_pkg::t_cmp             w_cmp;
    logic                      w_emit_valid;
    logic                      w_emit_ready;
    i2r_pkg::t_char            w_emit;

    logic                      w_err_beat;
    logic                      w_err_shape;
    logic                      w_text_beat;
    logic                      w_mid_text;
    logic                      w_in_beat;

    i2r_cmp_sub u_cmp_sub (
        .i_mag     (w_mag),
        .i_operand (w_operand),
        .o_res     (w_cmp)
    );

    i2r_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_mag        (w_mag),
        .o_operand    (w_operand),
        .i_cmp        (w_cmp),
        .o_emit_valid (w_emit_valid),
        .o_emit       (w_emit),
        .i_emit_ready (w_emit_ready)
    );

    i2r_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit_valid (w_emit_valid),
        .i_emit       (w_emit),
        .o_emit_ready (w_emit_ready),
        .o_out        (o_out)
    );

    assign w_err_beat  = o_out.valid && o_out.range_error;
    assign w_err_shape = o_out.last_char && (o_out.char_code == i2r_pkg::CHAR_NONE);
    assign w_text_beat = o_out.valid && !o_out.range_error;
    assign w_mid_text  = o_out.valid && !o_out.last_char;
    assign w_in_beat   = i_in.valid && i_in.ready;

    `I2R_ASSERT_IMPL(a_err_is_single, w_err_beat, w_err_shape)
    `I2R_ASSERT_IMPL(a_text_nonzero, w_text_beat, o_out.char_code != i2r_pkg::CHAR_NONE)
    `I2R_ASSERT_NEXT(a_busy_after_accept, w_in_beat, !i_in.ready)
    `I2R_ASSERT_IMPL(a_busy_mid_text, w_mid_text, !i_in.ready)

endmodule
